[sv/rrd_pkg.sv]
// rrd_pkg: shared types and constants for the range response decoder.
// Used by rrd_decoder, range_response_decoder and rrd_checker; no dependencies.

package rrd_pkg;

    localparam int DATA_CHARS_PER_LINE_DEF = 64;
    localparam int MAX_STEPS_DEF           = 1024;

    localparam int BYTE_W   = 8;
    localparam int STEP_W   = 10;
    localparam int DIST_W   = 18;
    localparam int DIGIT_W  = 6;
    localparam int GROUP_W  = 12;   // first two digits of a group
    localparam int LINE_W   = 3;
    localparam int SCNT_MAX = 1023;

    localparam int TDATA_OUT_W = 32;  // distance + step_index, padded to bytes
    localparam int TUSER_OUT_W = 2;

    // Character codes
    localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0d;
    localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0a;
    localparam logic [BYTE_W-1:0] CHAR_M    = 8'h4d;
    localparam logic [BYTE_W-1:0] CHAR_G    = 8'h47;
    localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_B    = 8'h62;
    localparam logic [DIGIT_W-1:0] DIGIT_OFFSET = 6'h30;

    // Line numbers with a meaning of their own
    localparam logic [LINE_W-1:0] LINE_ECHO   = 3'd0;
    localparam logic [LINE_W-1:0] LINE_FIRST  = 3'd1;
    localparam logic [LINE_W-1:0] LINE_FOUR   = 3'd4;
    localparam logic [LINE_W-1:0] LINE_STAMP  = 3'd5;
    localparam logic [LINE_W-1:0] LINE_DATA   = 3'd6;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_BAD    = 2'd2
    } kind_t;

    typedef struct packed {
        logic                valid;
        kind_t               kind;
        logic [DIST_W-1:0]   distance;
        logic [STEP_W-1:0]   step_index;
    } result_t;

endpackage

[sv/rrd_decoder.sv]
// rrd_decoder: reply parser state (line tracking, prefix, group assembly,
// sample count) and the per-byte decode. Depends on rrd_pkg.

module rrd_decoder #(
    parameter int DATA_CHARS_PER_LINE = rrd_pkg::DATA_CHARS_PER_LINE_DEF,
    parameter int MAX_STEPS           = rrd_pkg::MAX_STEPS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [rrd_pkg::BYTE_W-1:0]   rx_byte,
    input  logic [rrd_pkg::STEP_W-1:0]   first_step,
    output rrd_pkg::result_t             res
);

    // Position counter saturates above the data limit so "<= limit" stays exact
    localparam int POS_W = $clog2(DATA_CHARS_PER_LINE + 2);
    localparam logic [POS_W-1:0] POS_CAP   = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(DATA_CHARS_PER_LINE);
    localparam int LIM_INT = (MAX_STEPS - 1 > 1023) ? 1023 : MAX_STEPS - 1;
    localparam logic [rrd_pkg::STEP_W:0] IDX_LIMIT = (rrd_pkg::STEP_W + 1)'(LIM_INT);

    logic [rrd_pkg::LINE_W-1:0]  line_reg,   line_next;
    logic                        is_g_reg,   is_g_next;
    logic [POS_W-1:0]            pos_reg,    pos_next;
    logic [rrd_pkg::BYTE_W-1:0]  pfx_reg  [3];
    logic [rrd_pkg::BYTE_W-1:0]  pfx_next [3];
    logic                        held_v_reg, held_v_next;
    logic [rrd_pkg::DIGIT_W-1:0] held_reg,   held_next;   // low bits of the held char
    logic [rrd_pkg::GROUP_W-1:0] grp_reg,    grp_next;
    logic [1:0]                  gcnt_reg,   gcnt_next;
    logic [rrd_pkg::STEP_W-1:0]  scnt_reg,   scnt_next;

    logic [rrd_pkg::STEP_W:0]    idx_sum;
    logic [rrd_pkg::STEP_W-1:0]  cur_index;
    logic [rrd_pkg::DIGIT_W-1:0] digit;
    logic                        is_eol;
    logic                        is_99b;
    logic                        clear_all;

    assign idx_sum   = {1'b0, first_step} + {1'b0, scnt_reg};
    assign cur_index = (idx_sum > IDX_LIMIT) ? IDX_LIMIT[rrd_pkg::STEP_W-1:0]
                                             : idx_sum[rrd_pkg::STEP_W-1:0];
    assign digit     = held_reg - rrd_pkg::DIGIT_OFFSET;
    assign is_eol    = (rx_byte == rrd_pkg::CHAR_CR) || (rx_byte == rrd_pkg::CHAR_LF);
    assign is_99b    = (pos_reg >= POS_W'(3)) && (pfx_reg[0] == rrd_pkg::CHAR_NINE) &&
                       (pfx_reg[1] == rrd_pkg::CHAR_NINE) && (pfx_reg[2] == rrd_pkg::CHAR_B);

    always_comb
    begin
        line_next   = line_reg;
        is_g_next   = is_g_reg;
        pos_next    = pos_reg;
        pfx_next    = pfx_reg;
        held_v_next = held_v_reg;
        held_next   = held_reg;
        grp_next    = grp_reg;
        gcnt_next   = gcnt_reg;
        scnt_next   = scnt_reg;
        clear_all   = 1'b0;
        res         = '0;
        res.kind    = rrd_pkg::KIND_SAMPLE;

        if (is_eol)
        begin
            if ((line_reg >= rrd_pkg::LINE_DATA) && (pos_reg == '0))
            begin
                // empty data line: scan complete
                res.valid      = 1'b1;
                res.kind       = rrd_pkg::KIND_DONE;
                res.step_index = cur_index;
                clear_all      = 1'b1;
            end
            else if (line_reg == rrd_pkg::LINE_ECHO)
            begin
                if ((pos_reg == '0) ||
                    ((pfx_reg[0] != rrd_pkg::CHAR_M) && (pfx_reg[0] != rrd_pkg::CHAR_G)))
                begin
                    res.valid = 1'b1;
                    res.kind  = rrd_pkg::KIND_BAD;
                    clear_all = 1'b1;
                end
                else
                begin
                    is_g_next = (pfx_reg[0] == rrd_pkg::CHAR_G);
                    line_next = rrd_pkg::LINE_FIRST;
                end
            end
            else if ((line_reg < rrd_pkg::LINE_DATA) && is_99b)
            begin
                line_next = rrd_pkg::LINE_STAMP;
            end
            else if ((line_reg == rrd_pkg::LINE_FIRST) && is_g_reg)
            begin
                line_next = rrd_pkg::LINE_STAMP;
            end
            else if (line_reg == rrd_pkg::LINE_FOUR)
            begin
                res.valid = 1'b1;
                res.kind  = rrd_pkg::KIND_BAD;
                clear_all = 1'b1;
            end
            else if (line_reg < rrd_pkg::LINE_DATA)
            begin
                line_next = line_reg + rrd_pkg::LINE_W'(1);
            end

            // new line; the held char was the checksum and is dropped
            pos_next    = '0;
            held_v_next = 1'b0;
            held_next   = '0;
            pfx_next[0] = '0;
            pfx_next[1] = '0;
            pfx_next[2] = '0;
        end
        else
        begin
            if (pos_reg < POS_W'(3))
            begin
                case (pos_reg[1:0])
                    2'd0:    pfx_next[0] = rx_byte;
                    2'd1:    pfx_next[1] = rx_byte;
                    default: pfx_next[2] = rx_byte;
                endcase
            end
            if ((line_reg >= rrd_pkg::LINE_DATA) && (pos_reg <= POS_LIMIT))
            begin
                if (held_v_reg)
                begin
                    if (gcnt_reg == 2'd2)
                    begin
                        res.valid      = 1'b1;
                        res.kind       = rrd_pkg::KIND_SAMPLE;
                        res.distance   = {grp_reg, digit};
                        res.step_index = cur_index;
                        if (scnt_reg < rrd_pkg::STEP_W'(rrd_pkg::SCNT_MAX))
                            scnt_next = scnt_reg + rrd_pkg::STEP_W'(1);
                        grp_next  = '0;
                        gcnt_next = '0;
                    end
                    else
                    begin
                        grp_next  = {grp_reg[rrd_pkg::DIGIT_W-1:0], digit};
                        gcnt_next = gcnt_reg + 2'd1;
                    end
                end
                held_v_next = 1'b1;
                held_next   = rx_byte[rrd_pkg::DIGIT_W-1:0];
            end
            if (pos_reg < POS_CAP)
                pos_next = pos_reg + POS_W'(1);
        end

        if (clear_all)
        begin
            line_next   = rrd_pkg::LINE_ECHO;
            is_g_next   = 1'b0;
            grp_next    = '0;
            gcnt_next   = '0;
            scnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg   <= rrd_pkg::LINE_ECHO;
            is_g_reg   <= 1'b0;
            pos_reg    <= '0;
            pfx_reg[0] <= '0;
            pfx_reg[1] <= '0;
            pfx_reg[2] <= '0;
            held_v_reg <= 1'b0;
            held_reg   <= '0;
            grp_reg    <= '0;
            gcnt_reg   <= '0;
            scnt_reg   <= '0;
        end
        else if (en)
        begin
            line_reg   <= line_next;
            is_g_reg   <= is_g_next;
            pos_reg    <= pos_next;
            pfx_reg    <= pfx_next;
            held_v_reg <= held_v_next;
            held_reg   <= held_next;
            grp_reg    <= grp_next;
            gcnt_reg   <= gcnt_next;
            scnt_reg   <= scnt_next;
        end
    end

endmodule

[sv/range_response_decoder.sv]
// range_response_decoder: top level, stream ports, input and result registers.
// Depends on rrd_pkg and rrd_decoder.

// Decodes a laser range sensor reply arriving one received byte per
// transaction on s_axis. Lines end at CR or LF; the echo line must start with
// M or G, a "99b" status line leads to the timestamp line, and the lines after
// it carry the encoded distances (checksum char dropped). Every three data
// chars give one 18-bit distance, reported on m_axis with kind SAMPLE and its
// step index (first_step plus samples so far, saturating). An empty data line
// reports kind DONE with the next index; a malformed reply reports kind BAD.
// After DONE or BAD the decoder is back at the start of a new reply.
// Throughput: one byte per clock while no result stalls; each byte passes an
// input register, then the decode into the result register that drives m_axis.
// A stalled result holds the next byte in the input register; s_axis stalls
// once that register is occupied as well.
// The user must write first_step over the cfg channel only while the decoder is idle; the block does not enforce it.

module range_response_decoder #(
    parameter int DATA_CHARS_PER_LINE = rrd_pkg::DATA_CHARS_PER_LINE_DEF,
    parameter int MAX_STEPS           = rrd_pkg::MAX_STEPS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input bytes
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [rrd_pkg::BYTE_W-1:0]       s_axis_tdata,   // [7:0] rx_byte
    // decoded results
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rrd_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,   // [17:0] distance,
                                                             // [27:18] step_index,
                                                             // [31:28] zero
    output logic [rrd_pkg::TUSER_OUT_W-1:0]  m_axis_tuser,   // [1:0] kind
    // configuration: first_step
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rrd_pkg::STEP_W-1:0]       cfg_data
);

    localparam int PAD_W = rrd_pkg::TDATA_OUT_W - rrd_pkg::DIST_W - rrd_pkg::STEP_W;

    logic                          in_valid_reg;
    logic [rrd_pkg::BYTE_W-1:0]    in_byte_reg;
    logic [rrd_pkg::STEP_W-1:0]    first_step_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [rrd_pkg::DIST_W-1:0]    out_dist_reg;
    logic [rrd_pkg::STEP_W-1:0]    out_idx_reg;
    rrd_pkg::kind_t                out_kind_reg;

    logic                          out_free;
    logic                          advance;   // input register hands its byte to the decoder
    rrd_pkg::result_t              dec_res;

    // Result register can take a new value if empty or being drained this cycle
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign cfg_ready     = 1'b1;

    rrd_decoder #(
        .DATA_CHARS_PER_LINE (DATA_CHARS_PER_LINE),
        .MAX_STEPS           (MAX_STEPS)
    ) u_dec (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .rx_byte    (in_byte_reg),
        .first_step (first_step_reg),
        .res        (dec_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (advance && dec_res.valid)
            out_valid_next = 1'b1;
    end

    // Input register and config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            first_step_reg <= '0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (cfg_valid && cfg_ready)
                first_step_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && dec_res.valid)
        begin
            out_kind_reg <= dec_res.kind;
            out_dist_reg <= dec_res.distance;
            out_idx_reg  <= dec_res.step_index;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_idx_reg, out_dist_reg};
    assign m_axis_tuser  = out_kind_reg;

endmodule

[sv/rrd_checker.sv]
// rrd_checker: port-level assertions for range_response_decoder, with bind.
// Depends on rrd_pkg.

module rrd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [rrd_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
    input logic [rrd_pkg::TUSER_OUT_W-1:0]  m_axis_tuser
);

    // Bad reply carries neither distance nor index
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == rrd_pkg::KIND_BAD)) |-> (m_axis_tdata == '0))
        else $error("bad reply with nonzero payload");

    // Scan complete carries no distance
    a_done_nodist: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == rrd_pkg::KIND_DONE)) |->
        (m_axis_tdata[rrd_pkg::DIST_W-1:0] == '0))
        else $error("scan complete with nonzero distance");

    // Padding bits above step_index stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
        (m_axis_tdata[rrd_pkg::TDATA_OUT_W-1:rrd_pkg::DIST_W+rrd_pkg::STEP_W] == '0))
        else $error("tdata padding not zero");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

endmodule

bind range_response_decoder rrd_checker u_rrd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
